FILE: design/dllm_pkg.sv
// Package for the decaying load latency monitor.
// Widths, limits, register addresses and the sequencer state type.
`default_nettype none
package dllm_pkg;
    localparam int CNT_W = 32;
    localparam int SUM_W = 48;
    localparam int OUT_W = 16;
    localparam int RATE_W = 30;
    localparam int MAX_GAP_DEFAULT = 8;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_TARGET_AVG = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_TARGET_PEAK = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_AGE   = 7'b0000010,
        ST_ADD   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_QDIV  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage
`default_nettype wire

FILE: design/decaying_load_latency_monitor.sv
// Top level of the decaying load latency monitor: sequencer, accumulators, config port.
// Depends on dllm_pkg, dllm_mul and dllm_div.
`default_nettype none
// One request at a time. A request first ages the accumulators once per elapsed second (up to
// MAX_GAP_SECONDS), then decides. A sample is then added, goes through the serial multiplier
// and then the serial divider; a query takes two passes of the serial divider (average,
// then peak) and an output step. in_stall is high while a request is at work. The result
// waits in an output register; a query that finishes while the previous result is unread
// holds in its output state until that result is taken.
// No clearing pass after reset.
module decaying_load_latency_monitor #(
    parameter int MAX_GAP_SECONDS = dllm_pkg::MAX_GAP_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [dllm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  elapsed_seconds,
    input  wire logic        time_went_back,
    input  wire logic [7:0]  sample_count,
    input  wire logic [15:0] latency_ms,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [dllm_pkg::RATE_W-1:0] event_rate,
    output      logic [dllm_pkg::OUT_W-1:0]  avg_latency_ms,
    output      logic [dllm_pkg::OUT_W-1:0]  peak_latency_ms,
    output      logic        overloaded
);
    localparam int CW = dllm_pkg::CNT_W;
    localparam int SW = dllm_pkg::SUM_W;
    localparam int NW = SW + 2;
    localparam int DW = CW + 2;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [SW-1:0] SUM_MAX = '1;

    dllm_pkg::state_t st_reg, st_next;
    logic [15:0] tavg_reg, tavg_next, tpk_reg, tpk_next;
    logic [CW-1:0] cnt_reg, cnt_next, ev_reg, ev_next;
    logic [SW-1:0] lat_reg, lat_next, pk_reg, pk_next;
    logic [7:0] secs_reg, secs_next, sc_reg, sc_next;
    logic [15:0] lin_reg, lin_next;
    logic mode_reg, mode_next;
    logic [NW-1:0] avgq_reg, avgq_next;
    logic [NW-1:0] pkq_reg, pkq_next;
    logic ov_reg, ov_next;
    logic [dllm_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic [15:0] oavg_reg, oavg_next, opk_reg, opk_next;
    logic ovld_reg, ovld_next;
    logic accept, cfg_wr;
    dllm_pkg::div_ctl_t mctl, dctl;
    logic mdone, ddone;
    logic [CW+17:0] mprod;
    logic [NW-1:0] dnum, dquo;
    logic [DW-1:0] dden;
    logic [CW:0] cs, es;
    logic [SW:0] ls, ps;
    logic [SW-1:0] cand;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign in_stall = (st_reg != dllm_pkg::ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = ovld_reg;
    assign event_rate = rate_reg;
    assign avg_latency_ms = oavg_reg;
    assign peak_latency_ms = opk_reg;
    assign overloaded = ov_reg;

    always_comb
    begin
        unique case (paddr)
            dllm_pkg::ADDR_TARGET_AVG:  prdata = {16'd0, tavg_reg};
            dllm_pkg::ADDR_TARGET_PEAK: prdata = {16'd0, tpk_reg};
            default:                    prdata = '0;
        endcase
    end

    dllm_mul #(.AW(CW), .BW(18)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl_in(mctl),
        .a(ev_reg), .b({lin_reg, 2'b00}), .done(mdone), .prod(mprod)
    );

    dllm_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl_in(dctl),
        .num(dnum), .den(dden), .done(ddone), .quo(dquo)
    );

    always_comb
    begin
        st_next = st_reg;
        tavg_next = tavg_reg;
        tpk_next = tpk_reg;
        cnt_next = cnt_reg;
        ev_next = ev_reg;
        lat_next = lat_reg;
        pk_next = pk_reg;
        secs_next = secs_reg;
        sc_next = sc_reg;
        lin_next = lin_reg;
        mode_next = mode_reg;
        avgq_next = avgq_reg;
        pkq_next = pkq_reg;
        ov_next = ov_reg;
        rate_next = rate_reg;
        oavg_next = oavg_reg;
        opk_next = opk_reg;
        ovld_next = ovld_reg;
        mctl = '0;
        dctl = '0;
        dnum = '0;
        dden = '0;
        cs = {1'b0, cnt_reg} + (CW+1)'(sc_reg);
        es = {1'b0, ev_reg} + (CW+1)'(sc_reg);
        ls = {1'b0, lat_reg} + (SW+1)'(lin_reg);
        ps = {1'b0, pk_reg} + (SW+1)'(lin_reg);
        cand = '0;
        if (cfg_wr)
        begin
            unique case (paddr)
                dllm_pkg::ADDR_TARGET_AVG:  tavg_next = pwdata[15:0];
                dllm_pkg::ADDR_TARGET_PEAK: tpk_next = pwdata[15:0];
                default: ;
            endcase
        end
        if (ovld_reg && !out_stall)
            ovld_next = 1'b0;
        unique case (st_reg)
            dllm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    sc_next = sample_count;
                    lin_next = latency_ms;
                    secs_next = elapsed_seconds;
                    if (time_went_back || elapsed_seconds > 8'(MAX_GAP_SECONDS))
                    begin
                        cnt_next = '0;
                        ev_next = '0;
                        lat_next = '0;
                        pk_next = '0;
                        secs_next = '0;
                    end
                    st_next = dllm_pkg::ST_AGE;
                end
            end
            dllm_pkg::ST_AGE:
            begin
                if (secs_reg != 8'd0)
                begin
                    cnt_next = cnt_reg - CW'(({1'b0, cnt_reg} + 33'd3) >> 2);
                    ev_next = ev_reg - CW'(({1'b0, ev_reg} + 33'd3) >> 2);
                    lat_next = lat_reg - (lat_reg >> 2);
                    pk_next = pk_reg - (pk_reg >> 2);
                    secs_next = secs_reg - 8'd1;
                end
                else if (mode_reg)
                begin
                    if (ev_reg == '0)
                    begin
                        avgq_next = '0;
                        pkq_next = '0;
                        st_next = dllm_pkg::ST_OUT;
                    end
                    else
                    begin
                        dnum = {2'b00, lat_reg};
                        dden = {ev_reg, 2'b00};
                        dctl.start = 1'b1;
                        st_next = dllm_pkg::ST_QDIV;
                    end
                end
                else if (sc_reg == 8'd0)
                    st_next = dllm_pkg::ST_IDLE;
                else
                    st_next = dllm_pkg::ST_ADD;
            end
            dllm_pkg::ST_ADD:
            begin
                cnt_next = cs[CW] ? CNT_MAX : cs[CW-1:0];
                ev_next = es[CW] ? CNT_MAX : es[CW-1:0];
                lat_next = ls[SW] ? SUM_MAX : ls[SW-1:0];
                pk_next = ps[SW] ? SUM_MAX : ps[SW-1:0];
                st_next = dllm_pkg::ST_MUL;
            end
            dllm_pkg::ST_MUL:
            begin
                if (mdone)
                begin
                    dnum = NW'(mprod);
                    dden = DW'(sc_reg);
                    dctl.start = 1'b1;
                    st_next = dllm_pkg::ST_DIV;
                end
                else if (secs_reg != 8'hFF)
                begin
                    mctl.start = (secs_reg == 8'd0) && (sc_reg != 8'd0) && !mode_reg;
                    secs_next = 8'hFF;
                end
            end
            dllm_pkg::ST_DIV:
            begin
                if (ddone)
                begin
                    cand = (|dquo[NW-1:SW]) ? SUM_MAX : dquo[SW-1:0];
                    if (pk_reg < cand)
                        pk_next = cand;
                    secs_next = '0;
                    st_next = dllm_pkg::ST_IDLE;
                end
            end
            dllm_pkg::ST_QDIV:
            begin
                if (ddone)
                begin
                    if (secs_reg == 8'd0)
                    begin
                        avgq_next = dquo;
                        dnum = {2'b00, pk_reg};
                        dden = {ev_reg, 2'b00};
                        dctl.start = 1'b1;
                        secs_next = 8'd1;
                    end
                    else
                    begin
                        pkq_next = dquo;
                        secs_next = '0;
                        st_next = dllm_pkg::ST_OUT;
                    end
                end
            end
            dllm_pkg::ST_OUT:
            begin
                if (!ovld_reg || !out_stall)
                begin
                    ov_next = (tpk_reg != 16'd0 && pkq_reg > NW'(tpk_reg)) ||
                              (tavg_reg != 16'd0 && avgq_reg > NW'(tavg_reg));
                    oavg_next = (|avgq_reg[NW-1:16]) ? 16'hFFFF : avgq_reg[15:0];
                    opk_next = (|pkq_reg[NW-1:16]) ? 16'hFFFF : pkq_reg[15:0];
                    rate_next = cnt_reg[CW-1:2];
                    ovld_next = 1'b1;
                    st_next = dllm_pkg::ST_IDLE;
                end
            end
            default: st_next = dllm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= dllm_pkg::ST_IDLE;
            tavg_reg <= '0;
            tpk_reg <= '0;
            cnt_reg <= '0;
            ev_reg <= '0;
            lat_reg <= '0;
            pk_reg <= '0;
            ovld_reg <= 1'b0;
            secs_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            tavg_reg <= tavg_next;
            tpk_reg <= tpk_next;
            cnt_reg <= cnt_next;
            ev_reg <= ev_next;
            lat_reg <= lat_next;
            pk_reg <= pk_next;
            ovld_reg <= ovld_next;
            secs_reg <= secs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sc_reg <= sc_next;
        lin_reg <= lin_next;
        mode_reg <= mode_next;
        avgq_reg <= avgq_next;
        pkq_reg <= pkq_next;
        ov_reg <= ov_next;
        rate_reg <= rate_next;
        oavg_reg <= oavg_next;
        opk_reg <= opk_next;
    end
endmodule
`default_nettype wire

FILE: design/dllm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dllm_pkg for the control struct.
`default_nettype none
module dllm_div #(
    parameter int NW = 50,
    parameter int DW = 34
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dllm_pkg::div_ctl_t ctl_in,
    input  wire logic [NW-1:0]   num,
    input  wire logic [DW-1:0]   den,
    output      logic            done,
    output      logic [NW-1:0]   quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] c_reg, c_next;
    logic          run_reg, run_next;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;
    logic [NW-1:0] q_step;
    logic [DW:0]   r_step;

    always_comb
    begin
        shifted = {r_reg[DW-1:0], q_reg[NW-1]};
        trial = shifted - {1'b0, d_reg};
        q_step = {q_reg[NW-2:0], ~trial[DW]};
        r_step = trial[DW] ? shifted : trial;
        done = run_reg && (c_reg == CW'(1));
    end

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        c_next = c_reg;
        run_next = run_reg;
        if (ctl_in.start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            c_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next = q_step;
            r_next = r_step;
            c_next = c_reg - 1'b1;
            if (done)
                run_next = 1'b0;
        end
    end

    assign quo = q_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            c_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule
`default_nettype wire

FILE: design/dllm_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on dllm_pkg for the control struct.
`default_nettype none
module dllm_mul #(
    parameter int AW = 32,
    parameter int BW = 18
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dllm_pkg::div_ctl_t ctl_in,
    input  wire logic [AW-1:0]      a,
    input  wire logic [BW-1:0]      b,
    output      logic               done,
    output      logic [AW+BW-1:0]   prod
);
    localparam int CW = $clog2(BW + 1);
    logic [AW+BW-1:0] p_reg, p_next;
    logic [AW+BW-1:0] a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CW-1:0]    c_reg, c_next;
    logic             run_reg, run_next;
    logic [AW+BW-1:0] p_step;

    always_comb
    begin
        p_step = b_reg[0] ? p_reg + a_reg : p_reg;
        done = run_reg && (c_reg == CW'(1));
    end

    always_comb
    begin
        p_next = p_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        run_next = run_reg;
        if (ctl_in.start)
        begin
            p_next = '0;
            a_next = (AW+BW)'(a);
            b_next = b;
            c_next = CW'(BW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            p_next = p_step;
            a_next = {a_reg[AW+BW-2:0], 1'b0};
            b_next = b_reg >> 1;
            c_next = c_reg - 1'b1;
            if (done)
                run_next = 1'b0;
        end
    end

    assign prod = p_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            c_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end
endmodule
`default_nettype wire
